### rtl/vma_pkg.sv
package vma_pkg;
    localparam int MAX_PARTICLES_DEF = 1024;
    localparam int VEL_W  = 24;
    localparam int RAD_W  = 48;
    localparam int ROOT_W = 24;
    localparam int REF_W  = 25;
    localparam logic [31:0] SQRT2_Q30 = 32'd1518500250;
    localparam logic [31:0] INV_COUNT_RST = 32'h0100_0000;

    typedef logic [ROOT_W-1:0] t_root;
    typedef logic [RAD_W-1:0]  t_radicand;
endpackage

### rtl/velocity_moment_accumulator_unit.sv
// Velocity moment accumulator.
// Each word passes through the state machine; the 24-step square root is its longest part.
// A word marked last then waits for a free output register and forms ten scaled outputs,
// each through the select, low, high and sum states on the shared 32x32 multiplier; then offered.
// Input is stalled while a word is in work; a new word is taken only once the last is done.
// Synchronous active-low reset clears sums and index, loads config defaults; speed store kept.
module velocity_moment_accumulator_unit #(
    parameter int MAX_PARTICLES = vma_pkg::MAX_PARTICLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic signed [23:0] i_vx_velocity,
    input  logic signed [23:0] i_vy_velocity,
    input  logic [15:0] i_snapshot,
    input  logic [31:0] i_sample_time,
    input  logic        i_last_particle,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_snapshot_number,
    output logic signed [31:0] o_strain,
    output logic signed [31:0] o_mean_vx,
    output logic [47:0] o_mean_vx_sq,
    output logic signed [31:0] o_mean_vy,
    output logic [47:0] o_mean_vy_sq,
    output logic signed [31:0] o_mean_diag,
    output logic [47:0] o_mean_diag_sq,
    output logic [31:0] o_mean_speed,
    output logic [47:0] o_mean_speed_sq,
    output logic [47:0] o_speed_correlation
);
    import vma_pkg::*;

    localparam int IDX_W = $clog2(MAX_PARTICLES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_PARTICLES - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_VX2   = 4'd1;
    localparam logic [3:0] S_VY2   = 4'd2;
    localparam logic [3:0] S_DIAG  = 4'd3;
    localparam logic [3:0] S_DM    = 4'd4;
    localparam logic [3:0] S_DSQ   = 4'd5;
    localparam logic [3:0] S_DSQA  = 4'd6;
    localparam logic [3:0] S_SWAIT = 4'd7;
    localparam logic [3:0] S_SSQ   = 4'd8;
    localparam logic [3:0] S_COR   = 4'd9;
    localparam logic [3:0] S_CACC  = 4'd10;
    localparam logic [3:0] S_FWAIT = 4'd11;
    localparam logic [3:0] S_FSEL  = 4'd12;
    localparam logic [3:0] S_FLO   = 4'd13;
    localparam logic [3:0] S_FHI   = 4'd14;
    localparam logic [3:0] S_FSUM  = 4'd15;

    localparam logic [3:0] FK_VX     = 4'd0;
    localparam logic [3:0] FK_VX_SQ  = 4'd1;
    localparam logic [3:0] FK_VY     = 4'd2;
    localparam logic [3:0] FK_VY_SQ  = 4'd3;
    localparam logic [3:0] FK_DIAG   = 4'd4;
    localparam logic [3:0] FK_DG_SQ  = 4'd5;
    localparam logic [3:0] FK_SPEED  = 4'd6;
    localparam logic [3:0] FK_SP_SQ  = 4'd7;
    localparam logic [3:0] FK_CORR   = 4'd8;
    localparam logic [3:0] FK_STRAIN = 4'd9;

    localparam logic CFG_INV_COUNT = 1'b0;
    localparam logic CFG_STRAIN    = 1'b1;

    logic [3:0]  r_state;
    logic [3:0]  r_fk;
    logic [31:0] r_inv_count;
    logic [31:0] r_strain_rate;
    logic [IDX_W-1:0] r_idx;

    logic [47:0] r_sum_vx, r_sum_vy, r_sum_diag, r_sum_speed;
    logic [63:0] r_sum_vx_sq, r_sum_vy_sq, r_sum_diag_sq, r_sum_speed_sq, r_sum_corr;

    logic [23:0] r_ax, r_ay;
    logic [24:0] r_as;
    logic        r_sneg;
    logic [15:0] r_snap;
    logic [31:0] r_time;
    logic        r_last;
    logic [47:0] r_vx2;
    logic [25:0] r_dm;
    t_root       r_speed;
    logic [REF_W-1:0] r_ref;

    logic [31:0] mul_a, mul_b;
    logic [63:0] r_prod;
    logic [63:0] r_plo;
    logic [63:0] r_opnd;
    logic        r_neg;

    logic        r_out_valid;
    logic [15:0] r_o_snap;
    logic [31:0] r_o_strain, r_o_vx, r_o_vy, r_o_diag, r_o_speed;
    logic [47:0] r_o_vx_sq, r_o_vy_sq, r_o_diag_sq, r_o_speed_sq, r_o_corr;

    logic        accept;
    logic signed [24:0] sxy;
    logic [56:0] dm_round;
    logic [63:0] fres;
    logic [31:0] res_s32;
    logic [47:0] res_sq;
    logic [31:0] res_u32;
    logic [39:0] strain_q;
    logic [31:0] strain_s32;
    logic [47:0] diag_ext;
    logic        sqrt_start;
    logic        sqrt_done;
    t_root       sqrt_root;
    logic        ram_we;
    logic [REF_W-1:0] ram_rdata;

    function automatic logic [63:0] mag48(input logic [47:0] s);
        logic [47:0] m;
        m = s[47] ? (48'd0 - s) : s;
        return {16'd0, m};
    endfunction

    function automatic logic [31:0] sat_s32(input logic neg, input logic [63:0] q);
        logic [31:0] v;
        if (neg) begin
            v = (q >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - q[31:0]);
        end else begin
            v = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        end
        return v;
    endfunction

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign sxy        = 25'(i_vx_velocity) + 25'(i_vy_velocity);
    assign dm_round   = r_prod[56:0] + 57'h2000_0000;
    assign diag_ext   = r_sneg ? (48'd0 - 48'(r_dm)) : 48'(r_dm);
    assign sqrt_start = (r_state == S_DIAG);
    assign ram_we     = (r_state == S_SSQ) && (r_snap == 16'd0);

    assign fres       = r_prod + {32'd0, r_plo[63:32]};
    assign res_s32    = sat_s32(r_neg, fres);
    assign res_sq     = (fres[63:16] > 48'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : fres[63:16];
    assign res_u32    = (fres > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : fres[31:0];
    assign strain_q   = r_plo[63:24];
    assign strain_s32 = sat_s32(r_neg, {24'd0, strain_q});

    vma_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (r_vx2 + r_prod[47:0]),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    vma_ram #(
        .WIDTH (REF_W),
        .DEPTH (MAX_PARTICLES)
    ) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (r_idx),
        .i_wdata (REF_W'(r_speed)),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_VX2:  begin mul_a = 32'(r_ax);  mul_b = 32'(r_ax); end
            S_VY2:  begin mul_a = 32'(r_ay);  mul_b = 32'(r_ay); end
            S_DIAG: begin mul_a = 32'(r_as);  mul_b = SQRT2_Q30; end
            S_DSQ:  begin mul_a = 32'(r_dm);  mul_b = 32'(r_dm); end
            S_SSQ:  begin mul_a = 32'(r_speed); mul_b = 32'(r_speed); end
            S_COR:  begin mul_a = 32'(r_speed); mul_b = 32'(r_ref); end
            S_FLO: begin
                mul_a = r_opnd[31:0];
                mul_b = (r_fk == FK_STRAIN) ? r_time : r_inv_count;
            end
            S_FHI:  begin mul_a = r_opnd[63:32]; mul_b = r_inv_count; end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_count   <= INV_COUNT_RST;
            r_strain_rate <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_INV_COUNT: r_inv_count   <= i_cfg_data;
                CFG_STRAIN:    r_strain_rate <= i_cfg_data;
                default:       r_inv_count   <= r_inv_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_fk           <= FK_VX;
            r_idx          <= '0;
            r_out_valid    <= 1'b0;
            r_sum_vx       <= '0;
            r_sum_vy       <= '0;
            r_sum_diag     <= '0;
            r_sum_speed    <= '0;
            r_sum_vx_sq    <= '0;
            r_sum_vy_sq    <= '0;
            r_sum_diag_sq  <= '0;
            r_sum_speed_sq <= '0;
            r_sum_corr     <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_sum_vx <= r_sum_vx + 48'(i_vx_velocity);
                        r_sum_vy <= r_sum_vy + 48'(i_vy_velocity);
                        r_state  <= S_VX2;
                    end
                end
                S_VX2:  r_state <= S_VY2;
                S_VY2: begin
                    r_sum_vx_sq <= r_sum_vx_sq + r_prod;
                    r_state     <= S_DIAG;
                end
                S_DIAG: begin
                    r_sum_vy_sq <= r_sum_vy_sq + r_prod;
                    r_state     <= S_DM;
                end
                S_DM:   r_state <= S_DSQ;
                S_DSQ: begin
                    r_sum_diag <= r_sum_diag + diag_ext;
                    r_state    <= S_DSQA;
                end
                S_DSQA: begin
                    r_sum_diag_sq <= r_sum_diag_sq + r_prod;
                    r_state       <= S_SWAIT;
                end
                S_SWAIT: begin
                    if (sqrt_done) begin
                        r_state <= S_SSQ;
                    end
                end
                S_SSQ: begin
                    r_sum_speed <= r_sum_speed + 48'(r_speed);
                    r_state     <= S_COR;
                end
                S_COR: begin
                    r_sum_speed_sq <= r_sum_speed_sq + r_prod;
                    r_state        <= S_CACC;
                end
                S_CACC: begin
                    if (r_snap != 16'd0) begin
                        r_sum_corr <= r_sum_corr + r_prod;
                    end
                    if (r_last) begin
                        r_idx   <= '0;
                        r_state <= S_FWAIT;
                    end else begin
                        r_idx   <= (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_FWAIT: begin
                    if (!r_out_valid) begin
                        r_fk    <= FK_VX;
                        r_state <= S_FSEL;
                    end
                end
                S_FSEL: r_state <= S_FLO;
                S_FLO:  r_state <= S_FHI;
                S_FHI:  r_state <= S_FSUM;
                S_FSUM: begin
                    if (r_fk == FK_STRAIN) begin
                        r_out_valid    <= 1'b1;
                        r_sum_vx       <= '0;
                        r_sum_vy       <= '0;
                        r_sum_diag     <= '0;
                        r_sum_speed    <= '0;
                        r_sum_vx_sq    <= '0;
                        r_sum_vy_sq    <= '0;
                        r_sum_diag_sq  <= '0;
                        r_sum_speed_sq <= '0;
                        r_sum_corr     <= '0;
                        r_state        <= S_IDLE;
                    end else begin
                        r_fk    <= r_fk + 4'd1;
                        r_state <= S_FSEL;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ax   <= i_vx_velocity[23] ? (24'd0 - i_vx_velocity) : i_vx_velocity;
            r_ay   <= i_vy_velocity[23] ? (24'd0 - i_vy_velocity) : i_vy_velocity;
            r_as   <= sxy[24] ? (25'd0 - sxy) : sxy;
            r_sneg <= sxy[24];
            r_snap <= i_snapshot;
            r_time <= i_sample_time;
            r_last <= i_last_particle;
        end
        if (r_state == S_VX2) begin
            r_ref <= ram_rdata;
        end
        if (r_state == S_VY2) begin
            r_vx2 <= r_prod[47:0];
        end
        if (r_state == S_DM) begin
            r_dm <= dm_round[55:30];
        end
        if (r_state == S_SWAIT && sqrt_done) begin
            r_speed <= sqrt_root;
        end
        if (r_state == S_FSEL) begin
            case (r_fk)
                FK_VX:     begin r_opnd <= mag48(r_sum_vx);   r_neg <= r_sum_vx[47];   end
                FK_VY:     begin r_opnd <= mag48(r_sum_vy);   r_neg <= r_sum_vy[47];   end
                FK_DIAG:   begin r_opnd <= mag48(r_sum_diag); r_neg <= r_sum_diag[47]; end
                FK_VX_SQ:  begin r_opnd <= r_sum_vx_sq;        r_neg <= 1'b0; end
                FK_VY_SQ:  begin r_opnd <= r_sum_vy_sq;        r_neg <= 1'b0; end
                FK_DG_SQ:  begin r_opnd <= r_sum_diag_sq;      r_neg <= 1'b0; end
                FK_SPEED:  begin r_opnd <= 64'(r_sum_speed);   r_neg <= 1'b0; end
                FK_SP_SQ:  begin r_opnd <= r_sum_speed_sq;     r_neg <= 1'b0; end
                FK_CORR:   begin r_opnd <= r_sum_corr;         r_neg <= 1'b0; end
                default: begin
                    r_opnd <= r_strain_rate[31] ? 64'(32'd0 - r_strain_rate)
                                                : 64'(r_strain_rate);
                    r_neg  <= r_strain_rate[31];
                end
            endcase
        end
        if (r_state == S_FHI) begin
            r_plo <= r_prod;
        end
        if (r_state == S_FSUM) begin
            case (r_fk)
                FK_VX:    r_o_vx       <= res_s32;
                FK_VX_SQ: r_o_vx_sq    <= res_sq;
                FK_VY:    r_o_vy       <= res_s32;
                FK_VY_SQ: r_o_vy_sq    <= res_sq;
                FK_DIAG:  r_o_diag     <= res_s32;
                FK_DG_SQ: r_o_diag_sq  <= res_sq;
                FK_SPEED: r_o_speed    <= res_u32;
                FK_SP_SQ: r_o_speed_sq <= res_sq;
                FK_CORR:  r_o_corr     <= res_sq;
                default: begin
                    r_o_strain <= strain_s32;
                    r_o_snap   <= r_snap;
                end
            endcase
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_snapshot_number   = r_o_snap;
    assign o_strain            = r_o_strain;
    assign o_mean_vx           = r_o_vx;
    assign o_mean_vx_sq        = r_o_vx_sq;
    assign o_mean_vy           = r_o_vy;
    assign o_mean_vy_sq        = r_o_vy_sq;
    assign o_mean_diag         = r_o_diag;
    assign o_mean_diag_sq      = r_o_diag_sq;
    assign o_mean_speed        = r_o_speed;
    assign o_mean_speed_sq     = r_o_speed_sq;
    assign o_speed_correlation = r_o_corr;
endmodule

### rtl/vma_ram.sv
module vma_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/vma_sqrt.sv
module vma_sqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  vma_pkg::t_radicand i_radicand,
    output logic               o_done,
    output vma_pkg::t_root     o_root
);
    import vma_pkg::*;

    localparam logic [4:0] LAST_ITER = 5'(ROOT_W - 1);

    logic            r_busy;
    logic [4:0]      r_cnt;
    logic [RAD_W:0]  r_n;
    logic [RAD_W:0]  r_r;
    logic [RAD_W:0]  r_bit;
    logic [RAD_W:0]  trial;

    assign trial = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == LAST_ITER) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= {1'b0, i_radicand};
            r_r   <= '0;
            r_bit <= (RAD_W+1)'(1) << (2 * ROOT_W - 2);
        end else if (r_busy) begin
            if (r_n >= trial) begin
                r_n <= r_n - trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = !r_busy;
    assign o_root = r_r[ROOT_W-1:0];
endmodule

### test/tb_velocity_moment_accumulator_unit.sv
module tb_velocity_moment_accumulator_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import vma_pkg::*;

    localparam int NPART = 1024;
    localparam logic REG_INV_COUNT = 1'b0;
    localparam logic REG_STRAIN_RATE = 1'b1;
    localparam int DRAIN_CYCLES = 120;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

    typedef struct {
        logic [15:0] snap;
        logic [31:0] strain;
        logic [31:0] mvx;
        logic [47:0] mvx2;
        logic [31:0] mvy;
        logic [47:0] mvy2;
        logic [31:0] mdiag;
        logic [47:0] mdiag2;
        logic [31:0] mspeed;
        logic [47:0] mspeed2;
        logic [47:0] corr;
    } t_moments;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic i_cfg_index = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [23:0] i_vx_velocity = '0;
    logic signed [23:0] i_vy_velocity = '0;
    logic [15:0] i_snapshot = '0;
    logic [31:0] i_sample_time = '0;
    logic i_last_particle = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [15:0] o_snapshot_number;
    logic signed [31:0] o_strain, o_mean_vx, o_mean_vy, o_mean_diag;
    logic [47:0] o_mean_vx_sq, o_mean_vy_sq, o_mean_diag_sq, o_mean_speed_sq;
    logic [31:0] o_mean_speed;
    logic [47:0] o_speed_correlation;

    velocity_moment_accumulator_unit uut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic [31:0] inv_count;
    logic [31:0] rate_reg;
    logic [47:0] acc_vx, acc_vy, acc_diag, acc_speed;
    logic [63:0] acc_vx2, acc_vy2, acc_diag2, acc_speed2, acc_corr;
    int unsigned part_idx;
    logic [24:0] ref_speed [NPART];
    bit ref_written [NPART];

    t_moments moments_q[$];
    int errors = 0;
    int words_in = 0;
    int words_out = 0;
    bit sender_gaps = 1'b1;
    bit recv_gaps = 1'b1;
    bit recv_hold = 1'b0;
    int idle_count = 0;

    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'h1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] clamp_s32(input bit neg, input logic [63:0] q);
        if (neg) return (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
        return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    endfunction

    function automatic logic [31:0] scale_signed(input logic [47:0] s);
        logic [47:0] m;
        logic [95:0] p;
        m = s[47] ? -s : s;
        p = 96'(m) * 96'(inv_count);
        return clamp_s32(s[47], p[95:32]);
    endfunction

    function automatic logic [47:0] scale_sq(input logic [63:0] s);
        logic [95:0] p;
        p = (96'(s) * 96'(inv_count)) >> 48;
        return (p > 96'(MAX48)) ? MAX48 : p[47:0];
    endfunction

    function automatic void clear_accums();
        acc_vx = 0; acc_vy = 0; acc_diag = 0; acc_speed = 0;
        acc_vx2 = 0; acc_vy2 = 0; acc_diag2 = 0; acc_speed2 = 0; acc_corr = 0;
        part_idx = 0;
    endfunction

    function automatic void absorb_particle(input logic signed [23:0] vx,
            input logic signed [23:0] vy, input logic [15:0] snap,
            input logic [31:0] t, input bit last);
        logic [63:0] ax, ay, vx2, vy2, speed, dm, sxy_m;
        logic signed [24:0] sxy;
        logic [47:0] diag;
        logic [31:0] rate_m;
        logic [63:0] sq;
        t_moments r;
        ax = vx < 0 ? 64'(-64'(vx)) : 64'(vx);
        ay = vy < 0 ? 64'(-64'(vy)) : 64'(vy);
        vx2 = ax * ax;
        vy2 = ay * ay;
        speed = isqrt64(vx2 + vy2);
        sxy = 25'(vx) + 25'(vy);
        sxy_m = sxy < 0 ? 64'(-64'(sxy)) : 64'(sxy);
        dm = (sxy_m * 64'(SQRT2_Q30) + (64'h1 << 29)) >> 30;
        diag = sxy < 0 ? -dm[47:0] : dm[47:0];
        if (part_idx >= NPART) part_idx = 0;
        if (snap == 0) begin
            ref_speed[part_idx] = speed[24:0];
            ref_written[part_idx] = 1'b1;
        end else begin
            acc_corr += speed * 64'(ref_speed[part_idx]);
        end
        part_idx = (part_idx + 1 >= NPART) ? 0 : part_idx + 1;
        acc_vx += 48'(vx);
        acc_vy += 48'(vy);
        acc_diag += diag;
        acc_speed += speed[47:0];
        acc_vx2 += vx2;
        acc_vy2 += vy2;
        acc_diag2 += dm * dm;
        acc_speed2 += speed * speed;
        if (!last) return;
        rate_m = rate_reg[31] ? -rate_reg : rate_reg;
        sq = (64'(rate_m) * 64'(t)) >> 24;
        r.strain = clamp_s32(rate_reg[31], sq);
        r.snap = snap;
        r.mvx = scale_signed(acc_vx);
        r.mvx2 = scale_sq(acc_vx2);
        r.mvy = scale_signed(acc_vy);
        r.mvy2 = scale_sq(acc_vy2);
        r.mdiag = scale_signed(acc_diag);
        r.mdiag2 = scale_sq(acc_diag2);
        sq = 64'((96'(acc_speed) * 96'(inv_count)) >> 32);
        r.mspeed = (sq > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sq[31:0];
        r.mspeed2 = scale_sq(acc_speed2);
        r.corr = scale_sq(acc_corr);
        moments_q.push_back(r);
        clear_accums();
    endfunction

    // one word in; caller is aligned to a rising edge
    task automatic send_particle(input logic signed [23:0] vx,
            input logic signed [23:0] vy, input logic [15:0] snap,
            input logic [31:0] t, input bit last);
        int n;
        i_in_valid <= 1'b1;
        i_vx_velocity <= vx;
        i_vy_velocity <= vy;
        i_snapshot <= snap;
        i_sample_time <= t;
        i_last_particle <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        absorb_particle(vx, vy, snap, t, last);
        words_in++;
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 15);
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        wait (moments_q.size() == 0);
        @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        wait_idle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == REG_INV_COUNT) inv_count = val;
        else rate_reg = val;
    endtask

    function automatic logic [23:0] rand_vel();
        case ($urandom_range(0, 7))
            0: return 24'h7F_FFFF;
            1: return 24'h80_0000;
            2: return 24'(int'($urandom_range(0, 2000)) - 1000);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_snapshot();
        if (!ref_written[part_idx >= NPART ? 0 : part_idx]) return 16'd0;
        return ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
    endfunction

    task automatic send_batch(input int len, input logic [31:0] t);
        for (int k = 0; k < len; k++)
            send_particle(rand_vel(), rand_vel(), pick_snapshot(), t, k == len - 1);
    endtask

    task automatic test_directed();
        send_particle(24'sh7F_FFFF, 24'sh7F_FFFF, 16'd0, 32'hFFFF_FFFF, 1'b0);
        send_particle(-24'sh80_0000, -24'sh80_0000, 16'd0, 32'd0, 1'b0);
        send_particle(24'sd0, 24'sd0, 16'd0, 32'd0, 1'b0);
        send_particle(24'sh7F_FFFF, -24'sh80_0000, 16'd0, 32'h0001_0000, 1'b1);
        send_particle(-24'sh80_0000, 24'sh7F_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        send_particle(24'sd1, -24'sd1, 16'd1, 32'h8000_0000, 1'b0);
        send_particle(24'sd0, 24'sd0, 16'd0, 32'd5, 1'b0);
        send_particle(24'sd3, 24'sd4, 16'd7, 32'd5, 1'b1);
        send_particle(24'sh7F_FFFF, 24'sh7F_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        write_reg(REG_STRAIN_RATE, 32'h7FFF_FFFF);
        write_reg(REG_INV_COUNT, 32'hFFFF_FFFF);
        send_particle(24'sh7F_FFFF, 24'sh7F_FFFF, 16'd0, 32'hFFFF_FFFF, 1'b0);
        send_particle(24'sh7F_FFFF, 24'sh7F_FFFF, 16'd3, 32'hFFFF_FFFF, 1'b1);
        write_reg(REG_STRAIN_RATE, 32'h8000_0000);
        send_particle(-24'sh80_0000, -24'sh80_0000, 16'd2, 32'hFFFF_FFFF, 1'b1);
        write_reg(REG_INV_COUNT, 32'd0);
        send_particle(-24'sh80_0000, 24'sd7, 16'd0, 32'd1, 1'b1);
    endtask

    // overflowing batch: index wraps, means and speed saturate
    task automatic test_index_wrap();
        write_reg(REG_INV_COUNT, 32'hFFFF_FFFF);
        write_reg(REG_STRAIN_RATE, 32'h0100_0000);
        for (int k = 0; k < NPART + 6; k++)
            send_particle(24'sh7F_FFFF, ($urandom_range(0, 9) == 0) ? rand_vel() : 24'sh7F_FFFF,
                          16'd0, 32'($urandom), k == NPART + 5);
        write_reg(REG_INV_COUNT, 32'h0100_0000);
        send_batch(40, 32'($urandom));
    endtask

    task automatic test_backpressure();
        recv_hold = 1'b1;
        for (int b = 0; b < 6; b++) send_batch($urandom_range(1, 3), 32'($urandom));
        wait_idle();
        send_batch(5, 32'($urandom));
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 650) begin
            if ($urandom_range(0, 9) == 0) begin
                write_reg(REG_INV_COUNT, ($urandom_range(0, 3) == 0) ? 32'($urandom)
                          : 32'h1 << $urandom_range(20, 31));
                write_reg(REG_STRAIN_RATE, 32'($urandom));
            end
            begin
                int len;
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 200)
                                                   : $urandom_range(1, 12);
                send_batch(len, 32'($urandom));
                sent += len;
            end
            if (sent > 560) begin
                sender_gaps = 1'b0;
                recv_gaps = 1'b0;
            end
        end
    endtask

    // receiver stall bursts, plus one long hold-off
    initial begin
        int n;
        forever begin
            if (recv_hold) begin
                i_out_stall <= 1'b1;
                repeat (600) @(posedge i_clk);
                recv_hold = 1'b0;
            end else if (!recv_gaps) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                n = $urandom_range(1, 15);
                i_out_stall <= ($urandom_range(0, 2) == 0);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_moments e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (moments_q.size() == 0) begin
                $error("unexpected result word");
                errors++;
            end else begin
                e = moments_q.pop_front();
                words_out++;
                if (o_snapshot_number !== e.snap) begin
                    $error("snapshot_number exp %h got %h", e.snap, o_snapshot_number); errors++;
                end
                if (o_strain !== e.strain) begin
                    $error("strain exp %h got %h", e.strain, o_strain); errors++;
                end
                if (o_mean_vx !== e.mvx) begin
                    $error("mean_vx exp %h got %h", e.mvx, o_mean_vx); errors++;
                end
                if (o_mean_vx_sq !== e.mvx2) begin
                    $error("mean_vx_sq exp %h got %h", e.mvx2, o_mean_vx_sq); errors++;
                end
                if (o_mean_vy !== e.mvy) begin
                    $error("mean_vy exp %h got %h", e.mvy, o_mean_vy); errors++;
                end
                if (o_mean_vy_sq !== e.mvy2) begin
                    $error("mean_vy_sq exp %h got %h", e.mvy2, o_mean_vy_sq); errors++;
                end
                if (o_mean_diag !== e.mdiag) begin
                    $error("mean_diag exp %h got %h", e.mdiag, o_mean_diag); errors++;
                end
                if (o_mean_diag_sq !== e.mdiag2) begin
                    $error("mean_diag_sq exp %h got %h", e.mdiag2, o_mean_diag_sq); errors++;
                end
                if (o_mean_speed !== e.mspeed) begin
                    $error("mean_speed exp %h got %h", e.mspeed, o_mean_speed); errors++;
                end
                if (o_mean_speed_sq !== e.mspeed2) begin
                    $error("mean_speed_sq exp %h got %h", e.mspeed2, o_mean_speed_sq); errors++;
                end
                if (o_speed_correlation !== e.corr) begin
                    $error("speed_correlation exp %h got %h", e.corr, o_speed_correlation);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_wr_en)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        inv_count = INV_COUNT_RST;
        rate_reg = 32'd0;
        clear_accums();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_index_wrap();
        test_backpressure();
        test_random();
        wait_idle();
        $display("covered %0d particle words and %0d moment results", words_in, words_out);
        $display("config extremes, index wrap, saturation, hold-off and stall bursts exercised");
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

### filelist.f
rtl/vma_pkg.sv
rtl/vma_ram.sv
rtl/vma_sqrt.sv
rtl/velocity_moment_accumulator_unit.sv
test/tb_velocity_moment_accumulator_unit.sv
